// ===== sv/dlsik_pkg.sv =====
// Shared constants and types for the damped least-squares velocity IK unit
`timescale 1ns / 1ps

package dlsik_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int FIELD_W   = 32;
   localparam int DAMP_W    = 31;
   localparam logic [DAMP_W-1:0] DAMP_RESET = DAMP_W'(66);

   // Lower-triangle entries of J^T J, in the order A00 A10 A11 A20 A21 A22
   localparam int N_TRI = 6;
   localparam int N_DIM = 3;
   localparam int TRI_ROW [N_TRI] = '{0, 1, 1, 2, 2, 2};
   localparam int TRI_COL [N_TRI] = '{0, 0, 1, 0, 1, 2};

   typedef logic signed [FIELD_W-1:0] field_type;

endpackage

// ===== sv/dlsik_if.sv =====
// Channel interfaces: request, response and control register write
`timescale 1ns / 1ps

interface dlsik_req_if import dlsik_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type jac_r0c0, jac_r0c1, jac_r0c2;
   field_type jac_r1c0, jac_r1c1, jac_r1c2;
   field_type jac_r2c0, jac_r2c1, jac_r2c2;
   field_type vel_x, vel_y, vel_z;

   modport source (output valid, jac_r0c0, jac_r0c1, jac_r0c2, jac_r1c0, jac_r1c1,
                   jac_r1c2, jac_r2c0, jac_r2c1, jac_r2c2, vel_x, vel_y, vel_z,
                   input ready);
   modport sink   (input valid, jac_r0c0, jac_r0c1, jac_r0c2, jac_r1c0, jac_r1c1,
                   jac_r1c2, jac_r2c0, jac_r2c1, jac_r2c2, vel_x, vel_y, vel_z,
                   output ready);
endinterface

interface dlsik_rsp_if import dlsik_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type joint_rate_0, joint_rate_1, joint_rate_2;
   logic      singular;

   modport source (output valid, joint_rate_0, joint_rate_1, joint_rate_2, singular,
                   input ready);
   modport sink   (input valid, joint_rate_0, joint_rate_1, joint_rate_2, singular,
                   output ready);
endinterface

interface dlsik_csr_if import dlsik_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DAMP_W-1:0] damping;

   modport source (output valid, damping, input ready);
   modport sink   (input valid, damping, output ready);
endinterface

// ===== sv/dlsik_pipe.sv =====
// Payload delay line with a common advance enable
`timescale 1ns / 1ps

module dlsik_pipe import dlsik_pkg::*; #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) stage_ff[i] <= stage_ff[i-1];
      end
   end

   assign dout = stage_ff[DEPTH-1];

endmodule

// ===== sv/dlsik_mul.sv =====
// Two-stage fixed-point multiplier: magnitude product, then round and saturate
`timescale 1ns / 1ps

module dlsik_mul import dlsik_pkg::*; #(
   parameter int DW = DATA_WIDTH_DEF,
   parameter int FB = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [DW-1:0] a,
   input  logic signed [DW-1:0] b,
   output logic signed [DW-1:0] p
);

   localparam int PW = 2 * DW;
   localparam logic [PW-1:0] HALF = PW'(1) << (FB - 1);
   localparam logic [PW-1:0] VMAX = (PW'(1) << (DW - 1)) - PW'(1);

   logic [DW-1:0] ma, mb;
   logic [PW-1:0] prod_in, prod_ff;
   logic          neg_in, neg_ff;
   logic [PW-1:0] rnd, mag;
   logic signed [DW-1:0] p_in, p_ff;

   assign ma      = a[DW-1] ? (~a + 1'b1) : a;
   assign mb      = b[DW-1] ? (~b + 1'b1) : b;
   assign prod_in = PW'(ma) * PW'(mb);
   assign neg_in  = a[DW-1] ^ b[DW-1];

   // round the magnitude half away from zero, then saturate by sign
   always_comb begin
      rnd = prod_ff + HALF;
      mag = rnd >> FB;
      if (!neg_ff) begin
         p_in = (mag > VMAX) ? DW'(VMAX) : DW'(mag);
      end else if (mag > VMAX + PW'(1)) begin
         p_in = {1'b1, {(DW-1){1'b0}}};
      end else begin
         p_in = DW'(~mag + PW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         neg_ff  <= neg_in;
         p_ff    <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// ===== sv/dlsik_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, then round and saturate
`timescale 1ns / 1ps

module dlsik_div import dlsik_pkg::*; #(
   parameter int DW = DATA_WIDTH_DEF,
   parameter int FB = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [DW-1:0] a,
   input  logic signed [DW-1:0] d,
   output logic signed [DW-1:0] q
);

   localparam int N = DW + FB;
   localparam logic [N:0] VMAX = (N'(1) << (DW - 1)) - (N+1)'(1);

   logic [DW:0]   rem_ff [N];
   logic [N-1:0]  quo_ff [N];
   logic [N-1:0]  num_ff [N];
   logic [DW-1:0] den_ff [N];
   logic          neg_ff [N];

   logic [DW-1:0] ma;
   assign ma = a[DW-1] ? (~a + 1'b1) : a;

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic [DW:0]   rem_prev, rem_sh, rem_in;
      logic [N-1:0]  quo_prev, num_prev;
      logic [DW-1:0] den_prev;
      logic          neg_prev, ge;

      if (i == 0) begin : g_first
         assign rem_prev = '0;
         assign quo_prev = '0;
         assign num_prev = {ma, {FB{1'b0}}};
         assign den_prev = d;
         assign neg_prev = a[DW-1];
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign num_prev = num_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign neg_prev = neg_ff[i-1];
      end

      assign rem_sh = {rem_prev[DW-1:0], num_prev[N-1-i]};
      assign ge     = rem_sh >= {1'b0, den_prev};
      assign rem_in = ge ? (rem_sh - {1'b0, den_prev}) : rem_sh;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            quo_ff[i] <= {quo_prev[N-2:0], ge};
            num_ff[i] <= num_prev;
            den_ff[i] <= den_prev;
            neg_ff[i] <= neg_prev;
         end
      end
   end

   logic             rnd;
   logic [N:0]       qr;
   logic signed [DW-1:0] q_in, q_ff;

   always_comb begin
      rnd = {rem_ff[N-1], 1'b0} >= {2'b00, den_ff[N-1]};
      qr  = {1'b0, quo_ff[N-1]} + (N+1)'(rnd);
      if (!neg_ff[N-1]) begin
         q_in = (qr > VMAX) ? DW'(VMAX) : DW'(qr);
      end else if (qr > VMAX + (N+1)'(1)) begin
         q_in = {1'b1, {(DW-1){1'b0}}};
      end else begin
         q_in = DW'(~qr + (N+1)'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

// ===== sv/damped_least_squares_velocity_ik_unit.sv =====
// Damped least-squares velocity IK: pipelined LDL^T solve of (J^T J + damping I) dq = J^T v.
// The unit accepts one Jacobian and foot velocity every cycle while it is not held, and returns
// one result per item, in order. Most of the pipeline lies in three restoring dividers in
// series, each resolving one quotient bit per stage; the rest is two-stage multipliers and
// single-stage saturating adds. A stalled response holds the pipeline only while a finished
// result is waiting behind it. The damping register resets to 66 and must be written while the
// unit holds no item. A pivot that is zero or negative raises singular and forces the joint
// rates to zero.
`timescale 1ns / 1ps

module damped_least_squares_velocity_ik_unit import dlsik_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   dlsik_req_if.sink   req,
   dlsik_rsp_if.source rsp,
   dlsik_csr_if.sink   csr
);

   localparam int DW = DATA_WIDTH;
   localparam int FB = FRAC_BITS;
   localparam int ML = 2;
   localparam int DL = DW + FB + 1;

   localparam int S1  = ML;
   localparam int S4  = S1 + 3;
   localparam int S5  = S4 + DL;
   localparam int S7  = S5 + ML + 1;
   localparam int S8  = S7 + DL;
   localparam int S10 = S8 + ML + 1;
   localparam int S11 = S10 + DL;
   localparam int S13 = S11 + ML + 1;
   localparam int S16 = S13 + ML + 2;
   localparam int VL  = S16 + 1;

   localparam logic signed [64:0] VMAX65 = (65'sd1 <<< (DW - 1)) - 65'sd1;
   localparam logic signed [64:0] VMIN65 = -VMAX65 - 65'sd1;
   localparam logic signed [64:0] OMAX65 = 65'sd2147483647;
   localparam logic signed [64:0] OMIN65 = -65'sd2147483648;

   typedef logic signed [DW-1:0] word_type;

   function automatic word_type clamp_in(input logic signed [64:0] x);
      if (x > VMAX65) return DW'(VMAX65);
      if (x < VMIN65) return DW'(VMIN65);
      return DW'(x);
   endfunction

   function automatic field_type to_field(input word_type x);
      logic signed [64:0] w;
      w = 65'(x);
      if (w > OMAX65) return FIELD_W'(OMAX65);
      if (w < OMIN65) return FIELD_W'(OMIN65);
      return FIELD_W'(w);
   endfunction

   function automatic word_type sat_add(input word_type x, input word_type y);
      logic signed [DW:0] s;
      s = {x[DW-1], x} + {y[DW-1], y};
      if (s[DW] != s[DW-1]) return s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      return s[DW-1:0];
   endfunction

   function automatic word_type sat_sub(input word_type x, input word_type y);
      logic signed [DW:0] s;
      s = {x[DW-1], x} - {y[DW-1], y};
      if (s[DW] != s[DW-1]) return s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      return s[DW-1:0];
   endfunction

   function automatic logic nonpos(input word_type x);
      return x[DW-1] || (x == '0);
   endfunction

   // ---------------------------------------------------------------- control
   logic              adv;
   logic              vld_ff [VL];
   logic [DAMP_W-1:0] damping_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   // advance unless a finished item would collide with a waiting result
   assign adv       = !vld_ff[S16] || !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VL; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req.valid;
         for (int i = 1; i < VL; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff <= DAMP_RESET;
      end else if (csr.valid) begin
         damping_ff <= csr.damping;
      end
   end

   // ---------------------------------------------------------------- input stage
   word_type jm_ff [9];
   word_type vv_ff [N_DIM];
   word_type jm_in [9];
   word_type vv_in [N_DIM];

   assign jm_in[0] = clamp_in(65'(req.jac_r0c0));
   assign jm_in[1] = clamp_in(65'(req.jac_r0c1));
   assign jm_in[2] = clamp_in(65'(req.jac_r0c2));
   assign jm_in[3] = clamp_in(65'(req.jac_r1c0));
   assign jm_in[4] = clamp_in(65'(req.jac_r1c1));
   assign jm_in[5] = clamp_in(65'(req.jac_r1c2));
   assign jm_in[6] = clamp_in(65'(req.jac_r2c0));
   assign jm_in[7] = clamp_in(65'(req.jac_r2c1));
   assign jm_in[8] = clamp_in(65'(req.jac_r2c2));
   assign vv_in[0] = clamp_in(65'(req.vel_x));
   assign vv_in[1] = clamp_in(65'(req.vel_y));
   assign vv_in[2] = clamp_in(65'(req.vel_z));

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 9; i++) jm_ff[i] <= jm_in[i];
         for (int i = 0; i < N_DIM; i++) vv_ff[i] <= vv_in[i];
      end
   end

   // ---------------------------------------------------------------- J^T J and J^T v
   word_type pa [N_TRI][N_DIM];
   word_type pb [N_DIM][N_DIM];

   for (genvar e = 0; e < N_TRI; e++) begin : g_pa
      for (genvar k = 0; k < N_DIM; k++) begin : g_k
         dlsik_mul #(.DW(DW), .FB(FB)) u_mul (
            .clock(clock), .en(adv),
            .a(jm_ff[k*N_DIM + TRI_ROW[e]]), .b(jm_ff[k*N_DIM + TRI_COL[e]]),
            .p(pa[e][k]));
      end
   end

   for (genvar r = 0; r < N_DIM; r++) begin : g_pb
      for (genvar k = 0; k < N_DIM; k++) begin : g_k
         dlsik_mul #(.DW(DW), .FB(FB)) u_mul (
            .clock(clock), .en(adv),
            .a(jm_ff[k*N_DIM + r]), .b(vv_ff[k]), .p(pb[r][k]));
      end
   end

   word_type sa_ff [N_TRI], ta_ff [N_TRI], aa_ff [N_TRI], a4_ff [N_TRI];
   word_type sb_ff [N_DIM], tb_ff [N_DIM], bb_ff [N_DIM], b4_ff [N_DIM];
   word_type damp_w;

   assign damp_w = clamp_in(65'(damping_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < N_TRI; e++) begin
            sa_ff[e] <= sat_add(pa[e][0], pa[e][1]);
            ta_ff[e] <= pa[e][2];
            aa_ff[e] <= sat_add(sa_ff[e], ta_ff[e]);
            a4_ff[e] <= (TRI_ROW[e] == TRI_COL[e]) ? sat_add(aa_ff[e], damp_w) : aa_ff[e];
         end
         for (int r = 0; r < N_DIM; r++) begin
            sb_ff[r] <= sat_add(pb[r][0], pb[r][1]);
            tb_ff[r] <= pb[r][2];
            bb_ff[r] <= sat_add(sb_ff[r], tb_ff[r]);
            b4_ff[r] <= bb_ff[r];
         end
      end
   end

   // ---------------------------------------------------------------- first pivot
   word_type l10_5, l20_5, z0_5;
   word_type a10_5, a11_5, a20_5, a21_5, a22_5, b0_5, b1_5, b2_5;
   logic     sing_5;

   dlsik_div #(.DW(DW), .FB(FB)) u_div_l10 (
      .clock(clock), .en(adv), .a(a4_ff[1]), .d(a4_ff[0]), .q(l10_5));
   dlsik_div #(.DW(DW), .FB(FB)) u_div_l20 (
      .clock(clock), .en(adv), .a(a4_ff[3]), .d(a4_ff[0]), .q(l20_5));
   dlsik_div #(.DW(DW), .FB(FB)) u_div_z0 (
      .clock(clock), .en(adv), .a(b4_ff[0]), .d(a4_ff[0]), .q(z0_5));

   dlsik_pipe #(.W(8*DW+1), .DEPTH(DL)) u_dly5 (
      .clock(clock), .en(adv),
      .din({a4_ff[1], a4_ff[2], a4_ff[3], a4_ff[4], a4_ff[5],
            b4_ff[0], b4_ff[1], b4_ff[2], nonpos(a4_ff[0])}),
      .dout({a10_5, a11_5, a20_5, a21_5, a22_5, b0_5, b1_5, b2_5, sing_5}));

   word_type m1, m2, m3, m4, m5;
   word_type a11_6, a21_6, a22_6, b1_6, b2_6, l10_6, l20_6, z0_6;
   logic     sing_6;

   dlsik_mul #(.DW(DW), .FB(FB)) u_m1 (.clock(clock), .en(adv), .a(l10_5), .b(a10_5), .p(m1));
   dlsik_mul #(.DW(DW), .FB(FB)) u_m2 (.clock(clock), .en(adv), .a(l20_5), .b(a10_5), .p(m2));
   dlsik_mul #(.DW(DW), .FB(FB)) u_m3 (.clock(clock), .en(adv), .a(l20_5), .b(a20_5), .p(m3));
   dlsik_mul #(.DW(DW), .FB(FB)) u_m4 (.clock(clock), .en(adv), .a(l10_5), .b(b0_5), .p(m4));
   dlsik_mul #(.DW(DW), .FB(FB)) u_m5 (.clock(clock), .en(adv), .a(l20_5), .b(b0_5), .p(m5));

   dlsik_pipe #(.W(8*DW+1), .DEPTH(ML)) u_dly6 (
      .clock(clock), .en(adv),
      .din({a11_5, a21_5, a22_5, b1_5, b2_5, l10_5, l20_5, z0_5, sing_5}),
      .dout({a11_6, a21_6, a22_6, b1_6, b2_6, l10_6, l20_6, z0_6, sing_6}));

   word_type d1_ff, e21_ff, t22_ff, y1_ff, t2_ff, l10_7_ff, l20_7_ff, z0_7_ff;
   logic     sing_7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff     <= sat_sub(a11_6, m1);
         e21_ff    <= sat_sub(a21_6, m2);
         t22_ff    <= sat_sub(a22_6, m3);
         y1_ff     <= sat_sub(b1_6, m4);
         t2_ff     <= sat_sub(b2_6, m5);
         l10_7_ff  <= l10_6;
         l20_7_ff  <= l20_6;
         z0_7_ff   <= z0_6;
         sing_7_ff <= sing_6;
      end
   end

   // ---------------------------------------------------------------- second pivot
   word_type l21_8, z1_8, e21_8, t22_8, y1_8, t2_8, l10_8, l20_8, z0_8;
   logic     sing_8;

   dlsik_div #(.DW(DW), .FB(FB)) u_div_l21 (
      .clock(clock), .en(adv), .a(e21_ff), .d(d1_ff), .q(l21_8));
   dlsik_div #(.DW(DW), .FB(FB)) u_div_z1 (
      .clock(clock), .en(adv), .a(y1_ff), .d(d1_ff), .q(z1_8));

   dlsik_pipe #(.W(7*DW+1), .DEPTH(DL)) u_dly8 (
      .clock(clock), .en(adv),
      .din({e21_ff, t22_ff, y1_ff, t2_ff, l10_7_ff, l20_7_ff, z0_7_ff,
            sing_7_ff | nonpos(d1_ff)}),
      .dout({e21_8, t22_8, y1_8, t2_8, l10_8, l20_8, z0_8, sing_8}));

   word_type m6, m7;
   word_type l21_9, l10_9, l20_9, z0_9, z1_9, t22_9, t2_9;
   logic     sing_9;

   dlsik_mul #(.DW(DW), .FB(FB)) u_m6 (.clock(clock), .en(adv), .a(l21_8), .b(e21_8), .p(m6));
   dlsik_mul #(.DW(DW), .FB(FB)) u_m7 (.clock(clock), .en(adv), .a(l21_8), .b(y1_8), .p(m7));

   dlsik_pipe #(.W(7*DW+1), .DEPTH(ML)) u_dly9 (
      .clock(clock), .en(adv),
      .din({l21_8, l10_8, l20_8, z0_8, z1_8, t22_8, t2_8, sing_8}),
      .dout({l21_9, l10_9, l20_9, z0_9, z1_9, t22_9, t2_9, sing_9}));

   word_type d2_ff, y2_ff, l21_10_ff, l10_10_ff, l20_10_ff, z0_10_ff, z1_10_ff;
   logic     sing_10_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_ff      <= sat_sub(t22_9, m6);
         y2_ff      <= sat_sub(t2_9, m7);
         l21_10_ff  <= l21_9;
         l10_10_ff  <= l10_9;
         l20_10_ff  <= l20_9;
         z0_10_ff   <= z0_9;
         z1_10_ff   <= z1_9;
         sing_10_ff <= sing_9;
      end
   end

   // ---------------------------------------------------------------- third pivot
   word_type z2_11, l21_11, l10_11, l20_11, z0_11, z1_11;
   logic     sing_11;

   dlsik_div #(.DW(DW), .FB(FB)) u_div_z2 (
      .clock(clock), .en(adv), .a(y2_ff), .d(d2_ff), .q(z2_11));

   dlsik_pipe #(.W(5*DW+1), .DEPTH(DL)) u_dly11 (
      .clock(clock), .en(adv),
      .din({l21_10_ff, l10_10_ff, l20_10_ff, z0_10_ff, z1_10_ff,
            sing_10_ff | nonpos(d2_ff)}),
      .dout({l21_11, l10_11, l20_11, z0_11, z1_11, sing_11}));

   // ---------------------------------------------------------------- back substitution
   word_type m8;
   word_type x2_12, l10_12, l20_12, z0_12, z1_12;
   logic     sing_12;

   dlsik_mul #(.DW(DW), .FB(FB)) u_m8 (.clock(clock), .en(adv), .a(l21_11), .b(z2_11), .p(m8));

   dlsik_pipe #(.W(5*DW+1), .DEPTH(ML)) u_dly12 (
      .clock(clock), .en(adv),
      .din({z2_11, l10_11, l20_11, z0_11, z1_11, sing_11}),
      .dout({x2_12, l10_12, l20_12, z0_12, z1_12, sing_12}));

   word_type x1_13_ff, x2_13_ff, l10_13_ff, l20_13_ff, z0_13_ff;
   logic     sing_13_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_13_ff   <= sat_sub(z1_12, m8);
         x2_13_ff   <= x2_12;
         l10_13_ff  <= l10_12;
         l20_13_ff  <= l20_12;
         z0_13_ff   <= z0_12;
         sing_13_ff <= sing_12;
      end
   end

   word_type m9, m10;
   word_type z0_14, x1_14, x2_14;
   logic     sing_14;

   dlsik_mul #(.DW(DW), .FB(FB)) u_m9 (
      .clock(clock), .en(adv), .a(l10_13_ff), .b(x1_13_ff), .p(m9));
   dlsik_mul #(.DW(DW), .FB(FB)) u_m10 (
      .clock(clock), .en(adv), .a(l20_13_ff), .b(x2_13_ff), .p(m10));

   dlsik_pipe #(.W(3*DW+1), .DEPTH(ML)) u_dly14 (
      .clock(clock), .en(adv),
      .din({z0_13_ff, x1_13_ff, x2_13_ff, sing_13_ff}),
      .dout({z0_14, x1_14, x2_14, sing_14}));

   word_type u_15_ff, m10_15_ff, x1_15_ff, x2_15_ff;
   word_type x0_16_ff, x1_16_ff, x2_16_ff;
   logic     sing_15_ff, sing_16_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         u_15_ff    <= sat_sub(z0_14, m9);
         m10_15_ff  <= m10;
         x1_15_ff   <= x1_14;
         x2_15_ff   <= x2_14;
         sing_15_ff <= sing_14;
         x0_16_ff   <= sat_sub(u_15_ff, m10_15_ff);
         x1_16_ff   <= x1_15_ff;
         x2_16_ff   <= x2_15_ff;
         sing_16_ff <= sing_15_ff;
      end
   end

   // ---------------------------------------------------------------- response register
   field_type jr0_ff, jr1_ff, jr2_ff;
   logic      singular_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      if (adv && vld_ff[S16]) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // zero the rates of a singular item
   always_ff @(posedge clock) begin
      if (adv && vld_ff[S16]) begin
         jr0_ff      <= sing_16_ff ? '0 : to_field(x0_16_ff);
         jr1_ff      <= sing_16_ff ? '0 : to_field(x1_16_ff);
         jr2_ff      <= sing_16_ff ? '0 : to_field(x2_16_ff);
         singular_ff <= sing_16_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.joint_rate_0 = jr0_ff;
   assign rsp.joint_rate_1 = jr1_ff;
   assign rsp.joint_rate_2 = jr2_ff;
   assign rsp.singular     = singular_ff;

endmodule

// ===== tb/damped_least_squares_velocity_ik_unit_tb.sv =====
// Self-checking bench for the damped least-squares velocity IK unit
`timescale 1ns / 1ps

module damped_least_squares_velocity_ik_unit_tb;
   import dlsik_pkg::*;

   localparam int FRAC      = 16;
   localparam int LATENCY   = 3 * (32 + 16 + 1) + 19;
   localparam int WATCHDOG  = 20000;
   localparam int N_RANDOM  = 1400;
   localparam logic signed [63:0] QMAX = 64'sd2147483647;
   localparam logic signed [63:0] QMIN = -64'sd2147483648;

   typedef struct packed {
      field_type [8:0] jac;   // row-major
      field_type [2:0] vel;
   } leg_item_type;

   typedef struct packed {
      field_type rate0, rate1, rate2;
      logic      singular;
   } joint_rates_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dlsik_req_if req ();
   dlsik_rsp_if rsp ();
   dlsik_csr_if csr ();

   damped_least_squares_velocity_ik_unit uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   leg_item_type    pending_items[$];
   joint_rates_type expected_rates[$];
   logic [30:0]     damping_now;
   int              mismatches = 0;
   int              accepted = 0;
   int              received = 0;
   int              singular_seen = 0;
   int              idle_cycles = 0;
   bit              feed_hold = 1'b1;
   bit              stim_done = 1'b0;
   int              req_gap = 0;
   int              rsp_gap = 0;

   // ---------------- fixed-point predictor ----------------
   function automatic logic signed [63:0] sat_q(logic signed [127:0] v);
      if (v > 128'(QMAX)) return QMAX;
      if (v < 128'(QMIN)) return QMIN;
      return v[63:0];
   endfunction

   function automatic logic signed [63:0] q_add(logic signed [63:0] a, logic signed [63:0] b);
      return sat_q(128'(a) + 128'(b));
   endfunction

   function automatic logic signed [63:0] q_sub(logic signed [63:0] a, logic signed [63:0] b);
      return sat_q(128'(a) - 128'(b));
   endfunction

   function automatic logic signed [63:0] q_mul(logic signed [63:0] a, logic signed [63:0] b);
      logic [127:0]         mag;
      logic signed [127:0]  r;
      mag = (a < 0 ? 128'(-a) : 128'(a)) * (b < 0 ? 128'(-b) : 128'(b));
      mag = (mag + (128'd1 << (FRAC - 1))) >> FRAC;
      r   = ((a < 0) != (b < 0)) ? -$signed(mag) : $signed(mag);
      return sat_q(r);
   endfunction

   // divisor is always positive here
   function automatic logic signed [63:0] q_div(logic signed [63:0] a, logic signed [63:0] d);
      logic [127:0]        num, quo, rem;
      logic signed [127:0] r;
      num = (a < 0 ? 128'(-a) : 128'(a)) << FRAC;
      quo = num / 128'(d);
      rem = num % 128'(d);
      if (rem >= 128'(d) - rem) quo = quo + 1;
      r = (a < 0) ? -$signed(quo) : $signed(quo);
      return sat_q(r);
   endfunction

   function automatic joint_rates_type solve_joint_rates(leg_item_type it, logic [30:0] damp);
      logic signed [63:0] j[3][3];
      logic signed [63:0] v[3], b[3];
      logic signed [63:0] a[3][3];
      logic signed [63:0] d0, d1, d2, l10, l20, l21, e21, y0, y1, y2, z0, z1, z2, x0, x1, x2;
      joint_rates_type res;
      res = '{rate0: '0, rate1: '0, rate2: '0, singular: 1'b1};
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) j[r][c] = 64'(it.jac[r * 3 + c]);
         v[r] = 64'(it.vel[r]);
      end
      for (int r = 0; r < 3; r++) begin
         b[r] = q_mul(j[0][r], v[0]);
         for (int k = 1; k < 3; k++) b[r] = q_add(b[r], q_mul(j[k][r], v[k]));
         for (int c = 0; c <= r; c++) begin
            a[r][c] = q_mul(j[0][r], j[0][c]);
            for (int k = 1; k < 3; k++) a[r][c] = q_add(a[r][c], q_mul(j[k][r], j[k][c]));
         end
         a[r][r] = q_add(a[r][r], 64'(damp));
      end
      d0 = a[0][0];
      if (d0 <= 0) return res;
      l10 = q_div(a[1][0], d0);
      l20 = q_div(a[2][0], d0);
      d1  = q_sub(a[1][1], q_mul(l10, a[1][0]));
      if (d1 <= 0) return res;
      e21 = q_sub(a[2][1], q_mul(l20, a[1][0]));
      l21 = q_div(e21, d1);
      d2  = q_sub(q_sub(a[2][2], q_mul(l20, a[2][0])), q_mul(l21, e21));
      if (d2 <= 0) return res;
      y0 = b[0];
      y1 = q_sub(b[1], q_mul(l10, y0));
      y2 = q_sub(q_sub(b[2], q_mul(l20, y0)), q_mul(l21, y1));
      z0 = q_div(y0, d0);
      z1 = q_div(y1, d1);
      z2 = q_div(y2, d2);
      x2 = z2;
      x1 = q_sub(z1, q_mul(l21, x2));
      x0 = q_sub(q_sub(z0, q_mul(l10, x1)), q_mul(l20, x2));
      res.rate0 = x0[31:0];
      res.rate1 = x1[31:0];
      res.rate2 = x2[31:0];
      res.singular = 1'b0;
      return res;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic field_type rand_field();
      case ($urandom_range(0, 5))
         0: return field_type'($urandom);
         1: return 32'sh7FFFFFFF;
         2: return 32'sh80000000;
         default: return field_type'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
      endcase
   endfunction

   function automatic leg_item_type rand_leg();
      leg_item_type it;
      int           shape;
      shape = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
         if (shape < 6)
            it.jac[i] = field_type'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
         else
            it.jac[i] = rand_field();
      end
      for (int i = 0; i < 3; i++) it.vel[i] = shape < 5 ?
         field_type'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000) : rand_field();
      // rank-deficient leg: duplicate a column
      if (shape == 9) begin
         it.jac[2] = it.jac[1];
         it.jac[5] = it.jac[4];
         it.jac[8] = it.jac[7];
      end
      return it;
   endfunction

   function automatic leg_item_type fill_leg(field_type jv, field_type vv);
      leg_item_type it;
      for (int i = 0; i < 9; i++) it.jac[i] = jv;
      for (int i = 0; i < 3; i++) it.vel[i] = vv;
      return it;
   endfunction

   task automatic wait_drained();
      while (pending_items.size() != 0 || expected_rates.size() != 0) @(posedge clock);
      repeat (LATENCY / 4) @(posedge clock);
   endtask

   task automatic write_damping(logic [30:0] value);
      @(posedge clock);
      csr.valid   <= 1'b1;
      csr.damping <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid   <= 1'b0;
      damping_now = value;
   endtask

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req.valid && req.ready) begin
            expected_rates.push_back(solve_joint_rates(pending_items.pop_front(), damping_now));
            accepted++;
         end
         if (req.valid && !req.ready) begin
            // hold the offered transfer
         end else if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req.valid <= 1'b0;
         end else if (!feed_hold && pending_items.size() != 0 &&
                      !(req.valid && req.ready && pending_items.size() == 0)) begin
            req.valid    <= 1'b1;
            req.jac_r0c0 <= pending_items[0].jac[0];
            req.jac_r0c1 <= pending_items[0].jac[1];
            req.jac_r0c2 <= pending_items[0].jac[2];
            req.jac_r1c0 <= pending_items[0].jac[3];
            req.jac_r1c1 <= pending_items[0].jac[4];
            req.jac_r1c2 <= pending_items[0].jac[5];
            req.jac_r2c0 <= pending_items[0].jac[6];
            req.jac_r2c1 <= pending_items[0].jac[7];
            req.jac_r2c2 <= pending_items[0].jac[8];
            req.vel_x    <= pending_items[0].vel[0];
            req.vel_y    <= pending_items[0].vel[1];
            req.vel_z    <= pending_items[0].vel[2];
            req_gap      <= pick_gap();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_gap   <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            joint_rates_type got, want;
            got = '{rate0: rsp.joint_rate_0, rate1: rsp.joint_rate_1,
                    rate2: rsp.joint_rate_2, singular: rsp.singular};
            received++;
            if (got.singular) singular_seen++;
            if (expected_rates.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
               want = expected_rates.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected %p, got %p", received, want, got);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap   <= rsp_gap - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_gap <= pick_gap();
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------- sequence ----------------
   initial begin
      req.valid = 1'b0;
      req.jac_r0c0 = '0; req.jac_r0c1 = '0; req.jac_r0c2 = '0;
      req.jac_r1c0 = '0; req.jac_r1c1 = '0; req.jac_r1c2 = '0;
      req.jac_r2c0 = '0; req.jac_r2c1 = '0; req.jac_r2c2 = '0;
      req.vel_x = '0; req.vel_y = '0; req.vel_z = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.damping = '0;
      damping_now = DAMP_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, identity, zero, singular and saturating legs
      begin
         leg_item_type it;
         pending_items.push_back(fill_leg('0, '0));
         pending_items.push_back(fill_leg(32'sh7FFFFFFF, 32'sh7FFFFFFF));
         pending_items.push_back(fill_leg(32'sh80000000, 32'sh80000000));
         pending_items.push_back(fill_leg(32'sh80000000, 32'sh7FFFFFFF));
         pending_items.push_back(fill_leg(32'sh00010000, 32'shFFFF0000));
         it = fill_leg('0, 32'sh00010000);
         it.jac[0] = 32'sh00010000; it.jac[4] = 32'sh00010000; it.jac[8] = 32'sh00010000;
         pending_items.push_back(it);
         it.jac[4] = 32'sh80000000; it.vel[1] = 32'sh7FFFFFFF;
         pending_items.push_back(it);
         it = fill_leg('0, 32'sh00020000);
         it.jac[0] = 32'sh00000001; it.jac[4] = 32'sh7FFFFFFF; it.jac[8] = 32'sh00000100;
         pending_items.push_back(it);
         it = fill_leg(32'shAAAAAAAA, 32'sh55555555);
         pending_items.push_back(it);
         it = fill_leg(32'sh55555555, 32'shAAAAAAAA);
         pending_items.push_back(it);
         feed_hold = 1'b0;
         wait_drained();

         // zero damping: rank-deficient legs turn singular
         feed_hold = 1'b1;
         write_damping('0);
         pending_items.push_back(fill_leg('0, 32'sh00010000));
         pending_items.push_back(fill_leg(32'sh00010000, 32'sh00010000));
         it = fill_leg('0, 32'sh00010000);
         it.jac[0] = 32'sh00010000;
         pending_items.push_back(it);
         it.jac[4] = 32'sh00010000;
         pending_items.push_back(it);
         feed_hold = 1'b0;
         wait_drained();

         feed_hold = 1'b1;
         write_damping(31'h7FFFFFFF);
         pending_items.push_back(fill_leg('0, 32'sh7FFFFFFF));
         pending_items.push_back(fill_leg(32'sh00030000, 32'sh80000000));
         feed_hold = 1'b0;
         wait_drained();
      end

      // random phases under several damping settings; each phase drains first
      for (int phase = 0; phase < 7; phase++) begin
         feed_hold = 1'b1;
         case (phase)
            0: write_damping(31'd66);
            1: write_damping('0);
            2: write_damping(31'h7FFFFFFF);
            3: write_damping(31'd1);
            default: write_damping(31'($urandom_range(0, 32'h7FFFFFFF) >> $urandom_range(0, 30)));
         endcase
         for (int i = 0; i < N_RANDOM / 7; i++) pending_items.push_back(rand_leg());
         feed_hold = 1'b0;
         wait_drained();
      end

      $display("covered %0d legs under zero, small, reset and full-scale damping;", accepted);
      $display("%0d results checked, %0d of them singular", received, singular_seen);
      if (mismatches == 0 && expected_rates.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
